[rtl/core/nts_pkg.sv]
// ----------------------------------------------------------------------------
// nts_pkg
// shared widths, types and register codes of the nearest triangle search
// ----------------------------------------------------------------------------
package nts_pkg;

   localparam int COORD_W     = 24;
   localparam int NUM_AXES    = 3;
   localparam int NUM_VERTS   = 3;
   localparam int NUM_PTS     = 2;
   localparam int NUM_CAND    = 4;
   localparam int DIFF_W      = 27;
   localparam int SQ_W        = 52;
   localparam int DIST_W      = 53;
   localparam int IDX_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_TDATA_W = COORD_W * NUM_AXES * NUM_VERTS;
   localparam int RSP_TDATA_W = 2 * IDX_W;

   // point slots
   localparam int PT_START = 0;
   localparam int PT_GOAL  = 1;

   // axis slots
   localparam int AX_X = 0;
   localparam int AX_Y = 1;
   localparam int AX_Z = 2;

   // candidate slots, in compare order
   localparam int CAND_CENTROID = 0;
   localparam int CAND_VERT_A   = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X,
      CSR_START_Y,
      CSR_START_Z,
      CSR_GOAL_X,
      CSR_GOAL_Y,
      CSR_GOAL_Z
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [SQ_W-1:0]           sq_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic [IDX_W-1:0]          idx_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

[rtl/core/nts_dist.sv]
// ----------------------------------------------------------------------------
// nts_dist
// squared scaled distances of centroid and vertices to both points
// three register stages: differences, squares, sums
// ----------------------------------------------------------------------------
module nts_dist (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  nts_pkg::ctl_type   in_ctl,
   input  nts_pkg::coord_type in_vert [nts_pkg::NUM_VERTS][nts_pkg::NUM_AXES],
   input  nts_pkg::coord_type pts [nts_pkg::NUM_PTS][nts_pkg::NUM_AXES],
   output nts_pkg::ctl_type   out_ctl,
   output nts_pkg::dist_type  out_dist [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND]
);

   nts_pkg::ctl_type  ctl2_ff, ctl3_ff, ctl4_ff;
   nts_pkg::diff_type diff_in [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND][nts_pkg::NUM_AXES];
   nts_pkg::diff_type diff_ff [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND][nts_pkg::NUM_AXES];
   nts_pkg::sq_type   sq_in   [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND][nts_pkg::NUM_AXES];
   nts_pkg::sq_type   sq_ff   [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND][nts_pkg::NUM_AXES];
   nts_pkg::dist_type dist_in [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND];
   nts_pkg::dist_type dist_ff [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND];

   // centroid: (a+b+c) - 3p, vertex: 3(v-p)
   always_comb begin
      logic [nts_pkg::COORD_W+1:0] csum;
      logic [nts_pkg::COORD_W+1:0] p3;
      logic [nts_pkg::COORD_W+1:0] p26;
      logic [nts_pkg::COORD_W:0]   e;
      for (int p = 0; p < nts_pkg::NUM_PTS; p++) begin
         for (int ax = 0; ax < nts_pkg::NUM_AXES; ax++) begin
            csum = {{2{in_vert[0][ax][nts_pkg::COORD_W-1]}}, in_vert[0][ax]}
                 + {{2{in_vert[1][ax][nts_pkg::COORD_W-1]}}, in_vert[1][ax]}
                 + {{2{in_vert[2][ax][nts_pkg::COORD_W-1]}}, in_vert[2][ax]};
            p26  = {{2{pts[p][ax][nts_pkg::COORD_W-1]}}, pts[p][ax]};
            p3   = p26 + {p26[nts_pkg::COORD_W:0], 1'b0};
            diff_in[p][nts_pkg::CAND_CENTROID][ax] =
               {csum[nts_pkg::COORD_W+1], csum} - {p3[nts_pkg::COORD_W+1], p3};
            for (int k = 0; k < nts_pkg::NUM_VERTS; k++) begin
               e = {in_vert[k][ax][nts_pkg::COORD_W-1], in_vert[k][ax]}
                 - {pts[p][ax][nts_pkg::COORD_W-1], pts[p][ax]};
               diff_in[p][nts_pkg::CAND_VERT_A+k][ax] =
                  {{2{e[nts_pkg::COORD_W]}}, e} + {e[nts_pkg::COORD_W], e, 1'b0};
            end
         end
      end
   end

   always_comb begin
      logic signed [2*nts_pkg::DIFF_W-1:0] prod;
      for (int p = 0; p < nts_pkg::NUM_PTS; p++) begin
         for (int c = 0; c < nts_pkg::NUM_CAND; c++) begin
            for (int ax = 0; ax < nts_pkg::NUM_AXES; ax++) begin
               prod = diff_ff[p][c][ax] * diff_ff[p][c][ax];
               sq_in[p][c][ax] = prod[nts_pkg::SQ_W-1:0];
            end
         end
      end
   end

   always_comb begin
      for (int p = 0; p < nts_pkg::NUM_PTS; p++) begin
         for (int c = 0; c < nts_pkg::NUM_CAND; c++) begin
            dist_in[p][c] = nts_pkg::DIST_W'(sq_ff[p][c][nts_pkg::AX_X])
                          + nts_pkg::DIST_W'(sq_ff[p][c][nts_pkg::AX_Y])
                          + nts_pkg::DIST_W'(sq_ff[p][c][nts_pkg::AX_Z]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (advance) begin
         ctl2_ff <= in_ctl;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
         sq_ff   <= sq_in;
         dist_ff <= dist_in;
      end
   end

   assign out_ctl  = ctl4_ff;
   assign out_dist = dist_ff;

endmodule

[rtl/core/nts_min.sv]
// ----------------------------------------------------------------------------
// nts_min
// registered two-level minimum over the four candidates of each point
// ----------------------------------------------------------------------------
module nts_min (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  nts_pkg::ctl_type  in_ctl,
   input  nts_pkg::dist_type in_dist [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND],
   output nts_pkg::ctl_type  out_ctl,
   output nts_pkg::dist_type out_min [nts_pkg::NUM_PTS]
);

   nts_pkg::ctl_type  ctl5_ff, ctl6_ff;
   nts_pkg::dist_type pair_in [nts_pkg::NUM_PTS][2];
   nts_pkg::dist_type pair_ff [nts_pkg::NUM_PTS][2];
   nts_pkg::dist_type min_in  [nts_pkg::NUM_PTS];
   nts_pkg::dist_type min_ff  [nts_pkg::NUM_PTS];

   always_comb begin
      for (int p = 0; p < nts_pkg::NUM_PTS; p++) begin
         for (int h = 0; h < 2; h++) begin
            pair_in[p][h] = (in_dist[p][2*h+1] < in_dist[p][2*h]) ?
                            in_dist[p][2*h+1] : in_dist[p][2*h];
         end
         min_in[p] = (pair_ff[p][1] < pair_ff[p][0]) ? pair_ff[p][1] : pair_ff[p][0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (advance) begin
         ctl5_ff <= in_ctl;
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
         min_ff  <= min_in;
      end
   end

   assign out_ctl = ctl6_ff;
   assign out_min = min_ff;

endmodule

[rtl/core/nts_track.sv]
// ----------------------------------------------------------------------------
// nts_track
// best distance and triangle index per point, triangle count, result register
// ----------------------------------------------------------------------------
module nts_track #(
   parameter int MAX_TRIANGLES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  nts_pkg::ctl_type  in_ctl,
   input  nts_pkg::dist_type in_min [nts_pkg::NUM_PTS],
   input  logic              rsp_ready,
   output logic              advance,
   output logic              rsp_valid,
   output nts_pkg::idx_type  rsp_start_idx,
   output nts_pkg::idx_type  rsp_end_idx,
   output logic              rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              have_best_ff, have_best_in;
   logic              overflowed_ff, overflowed_in;
   nts_pkg::dist_type best_dist_ff [nts_pkg::NUM_PTS];
   nts_pkg::dist_type best_dist_in [nts_pkg::NUM_PTS];
   nts_pkg::idx_type  best_tri_ff  [nts_pkg::NUM_PTS];
   nts_pkg::idx_type  best_tri_in  [nts_pkg::NUM_PTS];
   logic              rsp_valid_ff, rsp_valid_in;
   nts_pkg::idx_type  rsp_start_ff, rsp_end_ff;
   logic              rsp_overflow_ff;
   logic              full;
   logic              take;
   logic              rsp_load;

   always_comb begin
      advance       = !(in_ctl.valid && in_ctl.last && rsp_valid_ff && !rsp_ready);
      full          = (cnt_ff == CNT_W'(MAX_TRIANGLES));
      take          = in_ctl.valid && !full;
      rsp_load      = advance && in_ctl.valid && in_ctl.last;
      cnt_in        = cnt_ff;
      have_best_in  = have_best_ff;
      overflowed_in = overflowed_ff || (in_ctl.valid && full);
      best_dist_in  = best_dist_ff;
      best_tri_in   = best_tri_ff;
      if (take) begin
         for (int p = 0; p < nts_pkg::NUM_PTS; p++) begin
            if (!have_best_ff || (in_min[p] < best_dist_ff[p])) begin
               best_dist_in[p] = in_min[p];
               best_tri_in[p]  = nts_pkg::IDX_W'(cnt_ff);
            end
         end
         have_best_in = 1'b1;
         cnt_in       = CNT_W'(cnt_ff + 1'b1);
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         have_best_ff  <= 1'b0;
         overflowed_ff <= 1'b0;
         best_tri_ff   <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            // end of mesh, back to the empty state
            cnt_ff        <= '0;
            have_best_ff  <= 1'b0;
            overflowed_ff <= 1'b0;
            best_tri_ff   <= '{default: '0};
         end else if (advance && in_ctl.valid) begin
            cnt_ff        <= cnt_in;
            have_best_ff  <= have_best_in;
            overflowed_ff <= overflowed_in;
            best_tri_ff   <= best_tri_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ctl.valid) begin
         best_dist_ff <= best_dist_in;
      end
      if (rsp_load) begin
         rsp_start_ff    <= best_tri_in[nts_pkg::PT_START];
         rsp_end_ff      <= best_tri_in[nts_pkg::PT_GOAL];
         rsp_overflow_ff <= overflowed_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_start_idx = rsp_start_ff;
   assign rsp_end_idx   = rsp_end_ff;
   assign rsp_overflow  = rsp_overflow_ff;

endmodule

[rtl/core/nearest_triangle_search_top.sv]
// ----------------------------------------------------------------------------
// nearest_triangle_search_top
// streaming search for the triangles nearest a start and a goal point
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  req     | in        | nine vertex coordinates, tlast = last triangle of mesh
//  rsp     | out       | start and end triangle index, tuser = overflow
//  csr     | in        | write of start and goal coordinates
//
// one triangle transfer per cycle while the pipeline is not held; the
// pipeline is seven register stages deep, the last being the result register
// all 24 distance multipliers work in parallel, one stage each
// the whole pipeline holds only while a last triangle reaches the tracker
// and the previous result has not been taken
// reset is synchronous and clears valid bits, counters and coordinates
// ----------------------------------------------------------------------------
module nearest_triangle_search_top #(
   parameter int MAX_TRIANGLES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [nts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // start_index, end_index
   output logic [nts_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // overflow
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [nts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nts_pkg::COORD_W-1:0]       csr_wdata
);

   logic               advance;
   nts_pkg::ctl_type   in_ctl_ff;
   nts_pkg::coord_type in_vert_ff [nts_pkg::NUM_VERTS][nts_pkg::NUM_AXES];
   nts_pkg::coord_type in_vert_in [nts_pkg::NUM_VERTS][nts_pkg::NUM_AXES];
   nts_pkg::coord_type pts_ff     [nts_pkg::NUM_PTS][nts_pkg::NUM_AXES];
   nts_pkg::ctl_type   dist_ctl;
   nts_pkg::dist_type  cand_dist [nts_pkg::NUM_PTS][nts_pkg::NUM_CAND];
   nts_pkg::ctl_type   min_ctl;
   nts_pkg::dist_type  min_dist [nts_pkg::NUM_PTS];
   nts_pkg::idx_type   start_idx, end_idx;

   always_comb begin
      for (int v = 0; v < nts_pkg::NUM_VERTS; v++) begin
         for (int ax = 0; ax < nts_pkg::NUM_AXES; ax++) begin
            in_vert_in[v][ax] =
               req_tdata[(v*nts_pkg::NUM_AXES+ax)*nts_pkg::COORD_W +: nts_pkg::COORD_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (advance) begin
         in_ctl_ff <= '{valid: req_tvalid, last: req_tlast};
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         in_vert_ff <= in_vert_in;
      end
   end

   // coordinate registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= '{default: '0};
      end else if (csr_we) begin
         case (csr_index)
            nts_pkg::CSR_START_X: pts_ff[nts_pkg::PT_START][nts_pkg::AX_X] <= csr_wdata;
            nts_pkg::CSR_START_Y: pts_ff[nts_pkg::PT_START][nts_pkg::AX_Y] <= csr_wdata;
            nts_pkg::CSR_START_Z: pts_ff[nts_pkg::PT_START][nts_pkg::AX_Z] <= csr_wdata;
            nts_pkg::CSR_GOAL_X:  pts_ff[nts_pkg::PT_GOAL][nts_pkg::AX_X]  <= csr_wdata;
            nts_pkg::CSR_GOAL_Y:  pts_ff[nts_pkg::PT_GOAL][nts_pkg::AX_Y]  <= csr_wdata;
            nts_pkg::CSR_GOAL_Z:  pts_ff[nts_pkg::PT_GOAL][nts_pkg::AX_Z]  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   nts_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (in_ctl_ff),
      .in_vert  (in_vert_ff),
      .pts      (pts_ff),
      .out_ctl  (dist_ctl),
      .out_dist (cand_dist)
   );

   nts_min u_min (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (dist_ctl),
      .in_dist  (cand_dist),
      .out_ctl  (min_ctl),
      .out_min  (min_dist)
   );

   nts_track #(
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (min_ctl),
      .in_min        (min_dist),
      .rsp_ready     (rsp_tready),
      .advance       (advance),
      .rsp_valid     (rsp_tvalid),
      .rsp_start_idx (start_idx),
      .rsp_end_idx   (end_idx),
      .rsp_overflow  (rsp_tuser)
   );

   assign req_tready = advance;
   assign rsp_tdata  = {end_idx, start_idx};

endmodule
